// ===== hdl/rom_ram_bank_controller_assert.svh =====
// Assertion macros used by the bank controller module.
`ifndef ROM_RAM_BANK_CONTROLLER_ASSERT_SVH
`define ROM_RAM_BANK_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rom_ram_bank_controller: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rom_ram_bank_controller: assertion failed");

`endif

// ===== hdl/rrbc_pkg.sv =====
package rrbc_pkg;

	localparam int RAM_BANKS      = 16;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int RAM_BYTES      = RAM_BANKS * RAM_BANK_BYTES;
	localparam int RAM_ADDR_BITS  = $clog2(RAM_BYTES);
	localparam int RAM_OFS_BITS   = $clog2(RAM_BANK_BYTES);
	localparam int RAM_BANK_BITS  = 4;
	localparam int ROM_BANK_BITS  = 9;
	localparam int ROM_CNT_BITS   = 10;
	localparam int RAM_CNT_BITS   = 5;
	localparam int ROM_ADDR_BITS  = 23;

	localparam logic [7:0] ENABLE_KEY = 8'h0A;
	localparam logic [7:0] OPEN_BUS   = 8'hFF;

	localparam logic [ROM_CNT_BITS-1:0]  ROM_CNT_RESET  = 10'd2;
	localparam logic [RAM_CNT_BITS-1:0]  RAM_CNT_RESET  = 5'd0;
	localparam logic [ROM_BANK_BITS-1:0] ROM_BANK_RESET = 9'd1;

	typedef enum logic {
		CFG_ROM_BANK_COUNT = 1'b0,
		CFG_RAM_BANK_COUNT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic                     rom_fetch;
		logic [ROM_ADDR_BITS-1:0] rom_address;
		logic                     ram_rd;
		logic                     ram_we;
		logic [RAM_ADDR_BITS-1:0] ram_addr;
		logic [7:0]               wdata;
	} req_t;

endpackage

// ===== hdl/rom_ram_bank_controller.sv =====
// Cartridge memory bank controller.
// The in channel carries one bus access per transfer: kind (0 read, 1 write),
// address and write_data. The out channel returns one result per access:
// rom_fetch with rom_address when the external ROM must supply the byte, and
// read_data with the RAM byte or 0xFF. Bank register writes take effect for the
// very next access.
// Each result is registered in the synchronous RAM read and then in the output
// register. The block takes one access per cycle while in_stall is low; the
// single RAM port serves one read or write per access.
// The cfg channel writes rom_bank_count (index 0) and ram_bank_count (index 1);
// cfg_ready is always high. Write it only while the block is idle.
// After reset the block clears the 131072-byte RAM, one byte a cycle, and holds
// in_stall high until the last byte is cleared.
// When the receiver stalls, the output register holds its result and one more
// access can still enter the RAM stage before in_stall rises.
module rom_ram_bank_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic [15:0]                        address,
	input  logic [7:0]                         write_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               rom_fetch,
	output logic [rrbc_pkg::ROM_ADDR_BITS-1:0] rom_address,
	output logic [7:0]                         read_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [31:0]                        cfg_data
);

	`include "rom_ram_bank_controller_assert.svh"

	rrbc_pkg::req_t                     req;
	logic                               in_accept;
	logic                               adv;
	logic                               clearing_q;
	logic [rrbc_pkg::RAM_ADDR_BITS-1:0] clr_addr_q;
	logic                               mem_en;
	logic                               mem_we;
	logic [rrbc_pkg::RAM_ADDR_BITS-1:0] mem_addr;
	logic [7:0]                         mem_wdata;
	logic [7:0]                         mem_rdata;

	logic                               valid_s1;
	logic                               rom_fetch_s1;
	logic [rrbc_pkg::ROM_ADDR_BITS-1:0] rom_address_s1;
	logic                               ram_rd_s1;

	logic                               out_valid_q;
	logic                               rom_fetch_q;
	logic [rrbc_pkg::ROM_ADDR_BITS-1:0] rom_address_q;
	logic [7:0]                         read_data_q;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = clearing_q || (valid_s1 && !adv);
	assign in_accept = in_valid && !in_stall;

	assign out_valid   = out_valid_q;
	assign rom_fetch   = rom_fetch_q;
	assign rom_address = rom_address_q;
	assign read_data   = read_data_q;

	rrbc_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (in_accept),
		.kind       (kind),
		.address    (address),
		.write_data (write_data),
		.req        (req)
	);

	always_comb begin
		mem_en    = clearing_q || (in_accept && (req.ram_rd || req.ram_we));
		mem_we    = clearing_q || (in_accept && req.ram_we);
		mem_addr  = clearing_q ? clr_addr_q : req.ram_addr;
		mem_wdata = clearing_q ? 8'h00 : req.wdata;
	end

	rrbc_ram #(
		.WIDTH     (8),
		.ADDR_BITS (rrbc_pkg::RAM_ADDR_BITS)
	) u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rom_fetch_s1   <= req.rom_fetch;
			rom_address_s1 <= req.rom_address;
			ram_rd_s1      <= req.ram_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rom_fetch_q   <= rom_fetch_s1;
			rom_address_q <= rom_address_s1;
			read_data_q   <= ram_rd_s1 ? mem_rdata : rrbc_pkg::OPEN_BUS;
		end
	end

	`RRBC_ASSERT_NOW(a_clear_blocks_input, clearing_q, in_stall)
	`RRBC_ASSERT_NOW(a_ram_write_needs_item, mem_we && !clearing_q, in_accept)
	`RRBC_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv, valid_s1 && $stable(rom_address_s1))
	`RRBC_ASSERT_NOW(a_fetch_open_bus, out_valid_q && rom_fetch_q,
		read_data_q == rrbc_pkg::OPEN_BUS)

endmodule

// ===== hdl/rrbc_ram.sv =====
module rrbc_ram #(
	parameter int WIDTH     = 8,
	parameter int ADDR_BITS = 17
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [WIDTH-1:0]     wdata,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== hdl/rrbc_decode.sv =====
module rrbc_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                accept,
	input  logic                kind,
	input  logic [15:0]         address,
	input  logic [7:0]          write_data,
	output rrbc_pkg::req_t      req
);

	logic [rrbc_pkg::ROM_CNT_BITS-1:0]  rom_bank_count_q;
	logic [rrbc_pkg::RAM_CNT_BITS-1:0]  ram_bank_count_q;
	logic [rrbc_pkg::ROM_BANK_BITS-1:0] rom_bank_q;
	logic [rrbc_pkg::RAM_BANK_BITS-1:0] ram_bank_q;
	logic                               ram_enabled_q;

	logic [rrbc_pkg::ROM_CNT_BITS-1:0]  rom_mask;
	logic [rrbc_pkg::ROM_BANK_BITS-1:0] bank_sel;
	logic                               fetch;
	logic                               ram_region;
	logic                               ram_ok;

	always_comb begin
		rom_mask = rom_bank_count_q - 10'd1;
		bank_sel = address[14] ? (rom_bank_q & rom_mask[rrbc_pkg::ROM_BANK_BITS-1:0])
			: '0;
		fetch = !kind && !address[15] && ({1'b0, bank_sel} < rom_bank_count_q);
		ram_region = (address[15:13] == 3'b101);
		ram_ok = ram_enabled_q && ram_region
			&& ({1'b0, ram_bank_q} < ram_bank_count_q)
			&& ({1'b0, ram_bank_q} < rrbc_pkg::RAM_CNT_BITS'(rrbc_pkg::RAM_BANKS));
		req.rom_fetch   = fetch;
		req.rom_address = fetch ? {bank_sel, address[13:0]} : '0;
		req.ram_rd      = ram_ok && !kind;
		req.ram_we      = ram_ok && kind;
		req.ram_addr    = rrbc_pkg::RAM_ADDR_BITS'({ram_bank_q,
			address[rrbc_pkg::RAM_OFS_BITS-1:0]});
		req.wdata       = write_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_count_q <= rrbc_pkg::ROM_CNT_RESET;
			ram_bank_count_q <= rrbc_pkg::RAM_CNT_RESET;
			rom_bank_q       <= rrbc_pkg::ROM_BANK_RESET;
			ram_bank_q       <= '0;
			ram_enabled_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (rrbc_pkg::cfg_index_t'(cfg_index))
					rrbc_pkg::CFG_ROM_BANK_COUNT: begin
						rom_bank_count_q <= cfg_data[rrbc_pkg::ROM_CNT_BITS-1:0];
					end
					rrbc_pkg::CFG_RAM_BANK_COUNT: begin
						ram_bank_count_q <= cfg_data[rrbc_pkg::RAM_CNT_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept && kind) begin
				if (address[15:13] == 3'b000) begin
					ram_enabled_q <= (write_data == rrbc_pkg::ENABLE_KEY);
				end else if (address[15:12] == 4'h2) begin
					rom_bank_q[7:0] <= write_data;
				end else if (address[15:12] == 4'h3) begin
					rom_bank_q[8] <= write_data[0];
				end else if (address[15:13] == 3'b010) begin
					ram_bank_q <= write_data[rrbc_pkg::RAM_BANK_BITS-1:0];
				end
			end
		end
	end

endmodule
